### rtl/uf_pkg.sv
// shared constants, types and helpers for the union-find engine
package uf_pkg;

  localparam int ELEMENTS = 1024;
  localparam int IDX_W    = $clog2(ELEMENTS);
  localparam int SZ_W     = $clog2(ELEMENTS + 1);
  localparam int GRD_W    = $clog2(ELEMENTS + 1);
  localparam int FIELD_W  = 10;

  localparam logic FUNC_QUERY = 1'b0;
  localparam logic FUNC_JOIN  = 1'b1;

  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [SZ_W-1:0]  size_t;
  typedef logic [GRD_W-1:0] guard_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_UP_RD,
    S_UP_CHK,
    S_CMP_RD,
    S_CMP_WR,
    S_SZ_A,
    S_SZ_B,
    S_SZ_CHK,
    S_DONE
  } state_t;

  typedef struct packed {
    logic we;
    idx_t waddr;
    idx_t wdata;
    idx_t raddr;
  } par_req_t;

  typedef struct packed {
    logic  we;
    idx_t  waddr;
    size_t wdata;
    idx_t  raddr;
  } sz_req_t;

  function automatic idx_t clamp_index(logic [FIELD_W-1:0] v);
    if (32'(v) >= ELEMENTS) begin
      return idx_t'(ELEMENTS - 1);
    end
    return idx_t'(v);
  endfunction

endpackage

### rtl/uf_ram.sv
// generic single-write, single-read ram with registered read data
module uf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/uf_seq.sv
// sequencer and walk datapath: root search, path compression, union by size
module uf_seq (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       req_valid,
  output logic                       req_stall,
  input  logic                       func,
  input  logic [uf_pkg::FIELD_W-1:0] elem_a,
  input  logic [uf_pkg::FIELD_W-1:0] elem_b,
  output logic                       rsp_valid,
  input  logic                       rsp_stall,
  output logic                       connected,
  output logic                       merged,
  output logic [uf_pkg::FIELD_W-1:0] root_a,
  output uf_pkg::par_req_t           par_req,
  input  uf_pkg::idx_t               par_rdata,
  output uf_pkg::sz_req_t            sz_req,
  input  uf_pkg::size_t              sz_rdata
);
  import uf_pkg::*;

  state_t state, state_next;

  idx_t   clr_idx;
  logic   side;
  idx_t   cur;
  idx_t   root;
  guard_t guard;
  idx_t   a_idx;
  idx_t   b_idx;
  logic   is_join;
  idx_t   ra;
  idx_t   rb;
  logic   conn;
  logic   mrg;
  size_t  size_a;

  logic slot_free;
  logic guard_max;
  logic up_more;
  logic cmp_done;
  logic b_wins;
  idx_t big;
  idx_t small_root;

  assign slot_free  = !rsp_valid || !rsp_stall;
  assign guard_max  = (guard == GRD_W'(ELEMENTS));
  assign up_more    = (par_rdata != cur) && !guard_max;
  assign cmp_done   = (cur == root) || guard_max;
  // equal sizes keep the first element's root
  assign b_wins     = (size_a < sz_rdata);
  assign big        = b_wins ? rb : ra;
  assign small_root = b_wins ? ra : rb;
  assign req_stall  = (state != S_IDLE);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR: begin
        if (clr_idx == idx_t'(ELEMENTS - 1)) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (req_valid) state_next = S_UP_RD;
      end
      S_UP_RD:  state_next = S_UP_CHK;
      S_UP_CHK: state_next = up_more ? S_UP_RD : S_CMP_RD;
      S_CMP_RD: begin
        if (!cmp_done) begin
          state_next = S_CMP_WR;
        end else if (!side) begin
          state_next = S_UP_RD;
        end else if (is_join && (ra != root)) begin
          state_next = S_SZ_A;
        end else begin
          state_next = S_DONE;
        end
      end
      S_CMP_WR: state_next = S_CMP_RD;
      S_SZ_A:   state_next = S_SZ_B;
      S_SZ_B:   state_next = S_SZ_CHK;
      S_SZ_CHK: state_next = S_DONE;
      S_DONE: begin
        if (slot_free) state_next = S_IDLE;
      end
      default:  state_next = S_CLEAR;
    endcase
  end

  // memory requests
  always_comb begin
    par_req.we    = 1'b0;
    par_req.waddr = cur;
    par_req.wdata = root;
    par_req.raddr = cur;
    sz_req.we     = 1'b0;
    sz_req.waddr  = ra;
    sz_req.wdata  = size_t'(size_a + sz_rdata);
    sz_req.raddr  = ra;
    case (state)
      S_CLEAR: begin
        par_req.we    = 1'b1;
        par_req.waddr = clr_idx;
        par_req.wdata = clr_idx;
        sz_req.we     = 1'b1;
        sz_req.waddr  = clr_idx;
        sz_req.wdata  = size_t'(1);
      end
      S_CMP_WR: begin
        par_req.we = 1'b1;
      end
      S_SZ_B: begin
        sz_req.raddr = rb;
      end
      S_SZ_CHK: begin
        sz_req.we     = 1'b1;
        sz_req.waddr  = big;
        par_req.we    = 1'b1;
        par_req.waddr = small_root;
        par_req.wdata = big;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_idx   <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_CLEAR) clr_idx <= clr_idx + idx_t'(1);
      if (state == S_DONE && slot_free) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // walk datapath
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        a_idx   <= clamp_index(elem_a);
        b_idx   <= clamp_index(elem_b);
        cur     <= clamp_index(elem_a);
        side    <= 1'b0;
        guard   <= '0;
        is_join <= (func == FUNC_JOIN);
        mrg     <= 1'b0;
      end
      S_UP_CHK: begin
        if (up_more) begin
          cur   <= par_rdata;
          guard <= guard + guard_t'(1);
        end else begin
          root  <= cur;
          cur   <= side ? b_idx : a_idx;
          guard <= '0;
        end
      end
      S_CMP_RD: begin
        if (cmp_done) begin
          if (!side) begin
            ra    <= root;
            side  <= 1'b1;
            cur   <= b_idx;
            guard <= '0;
          end else begin
            rb   <= root;
            conn <= (ra == root);
          end
        end
      end
      S_CMP_WR: begin
        // parent entry of cur is rewritten this cycle, follow the old link
        cur   <= par_rdata;
        guard <= guard + guard_t'(1);
      end
      S_SZ_B: begin
        size_a <= sz_rdata;
      end
      S_SZ_CHK: begin
        ra  <= big;
        mrg <= 1'b1;
      end
      S_DONE: begin
        if (slot_free) begin
          connected <= conn;
          merged    <= mrg;
          root_a    <= FIELD_W'(ra);
        end
      end
      default: begin
      end
    endcase
  end

endmodule

### rtl/union_find_engine_core.sv
// top level of the union-find engine: parent and size memories plus sequencer
// Disjoint-set engine over 1024 elements with union by size and full path
// compression. After reset the block runs a clearing pass over all entries
// (one parent and size entry per cycle) with req_stall high. Each item walks
// elem_a and elem_b up to their roots and compresses both paths, and a join
// that merges two sets also reads and updates the size memory; the root walk
// and the compression walk both go through the single read port of the parent
// memory. Items are taken one at a time; a finished result waits in the output
// register while the next item is accepted and worked on.
module union_find_engine_core (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       req_valid,
  output logic                       req_stall,
  input  logic                       func,
  input  logic [uf_pkg::FIELD_W-1:0] elem_a,
  input  logic [uf_pkg::FIELD_W-1:0] elem_b,
  output logic                       rsp_valid,
  input  logic                       rsp_stall,
  output logic                       connected,
  output logic                       merged,
  output logic [uf_pkg::FIELD_W-1:0] root_a
);
  import uf_pkg::*;

  par_req_t par_req;
  sz_req_t  sz_req;
  idx_t     par_rdata;
  size_t    sz_rdata;

  uf_ram #(
    .WIDTH(IDX_W),
    .DEPTH(ELEMENTS)
  ) u_parent_ram (
    .clk  (clk),
    .we   (par_req.we),
    .waddr(par_req.waddr),
    .wdata(par_req.wdata),
    .raddr(par_req.raddr),
    .rdata(par_rdata)
  );

  uf_ram #(
    .WIDTH(SZ_W),
    .DEPTH(ELEMENTS)
  ) u_size_ram (
    .clk  (clk),
    .we   (sz_req.we),
    .waddr(sz_req.waddr),
    .wdata(sz_req.wdata),
    .raddr(sz_req.raddr),
    .rdata(sz_rdata)
  );

  uf_seq u_seq (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .func     (func),
    .elem_a   (elem_a),
    .elem_b   (elem_b),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .connected(connected),
    .merged   (merged),
    .root_a   (root_a),
    .par_req  (par_req),
    .par_rdata(par_rdata),
    .sz_req   (sz_req),
    .sz_rdata (sz_rdata)
  );

endmodule

### tb/tb.sv
// testbench for union_find_engine_core: joins and queries checked against a disjoint-set predictor
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import uf_pkg::*;

  localparam int CYCLE_LIMIT  = 1_500_000;
  localparam int RANDOM_ITEMS = 1800;
  localparam int BLOCK        = 16;
  localparam int DRAIN_CYCLES = 200;

  typedef struct packed {
    logic               conn;
    logic               merged;
    logic [FIELD_W-1:0] root;
  } dsu_result_t;

  class dsu_scoreboard;
    idx_t        parent[ELEMENTS];
    size_t       set_sz[ELEMENTS];
    dsu_result_t pending_results[$];
    int          errors;
    int          noted;

    function new();
      for (int i = 0; i < ELEMENTS; i++) begin
        parent[i] = idx_t'(i);
        set_sz[i] = size_t'(1);
      end
      errors = 0;
      noted  = 0;
    endfunction

    // root walk, then rewrite every entry on the path to point at the root
    function idx_t walk_to_root(idx_t x);
      idx_t r;
      idx_t nxt;
      int   guard;
      r = x;
      guard = 0;
      while (parent[r] != r && guard < ELEMENTS) begin
        r = parent[r];
        guard++;
      end
      guard = 0;
      while (x != r && guard < ELEMENTS) begin
        nxt = parent[x];
        parent[x] = r;
        x = nxt;
        guard++;
      end
      return r;
    endfunction

    function idx_t saturate(logic [FIELD_W-1:0] v);
      if (int'(v) >= ELEMENTS) begin
        return idx_t'(ELEMENTS - 1);
      end
      return idx_t'(v);
    endfunction

    function void note_item(logic f, logic [FIELD_W-1:0] a, logic [FIELD_W-1:0] b);
      idx_t        ra;
      idx_t        rb;
      idx_t        big;
      idx_t        lesser;
      dsu_result_t res;
      ra = walk_to_root(saturate(a));
      rb = walk_to_root(saturate(b));
      res.conn   = (ra == rb);
      res.merged = 1'b0;
      if (f == FUNC_JOIN && ra != rb) begin
        // ties keep the first element's root
        big    = ra;
        lesser = rb;
        if (set_sz[ra] < set_sz[rb]) begin
          big    = rb;
          lesser = ra;
        end
        set_sz[big]    = set_sz[big] + set_sz[lesser];
        parent[lesser] = big;
        res.merged     = 1'b1;
        ra             = big;
      end
      res.root = ra[FIELD_W-1:0];
      pending_results = {pending_results, res};
      noted++;
    endfunction

    function void check_result(logic c, logic m, logic [FIELD_W-1:0] r);
      dsu_result_t want;
      if (pending_results.size() == 0) begin
        errors++;
        if (errors <= 10) begin
          $display("result with nothing pending: connected=%0d merged=%0d root_a=%0d",
                   c, m, r);
        end
        return;
      end
      want = pending_results.pop_front();
      if (c !== want.conn || m !== want.merged || r !== want.root) begin
        errors++;
        if (errors <= 10) begin
          $display("mismatch: connected %0d/%0d merged %0d/%0d root_a %0d/%0d (exp/got)",
                   want.conn, c, want.merged, m, want.root, r);
        end
      end
    endfunction

    function int pending();
      return pending_results.size();
    endfunction
  endclass

  logic               clk;
  logic               rst;
  logic               req_valid;
  logic               req_stall;
  logic               func;
  logic [FIELD_W-1:0] elem_a;
  logic [FIELD_W-1:0] elem_b;
  logic               rsp_valid;
  logic               rsp_stall;
  logic               connected;
  logic               merged;
  logic [FIELD_W-1:0] root_a;

  dsu_scoreboard sb;
  bit            calm;
  int            cycles;
  int            hold_left;
  int            run_left;
  bit            held;

  union_find_engine_core uut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .func      (func),
    .elem_a    (elem_a),
    .elem_b    (elem_b),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .connected (connected),
    .merged    (merged),
    .root_a    (root_a)
  );

  initial begin
    clk = 1'b0;
  end

  always #6 clk = ~clk;

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    if (calm) begin
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 40) begin
      return 0;
    end else if (r < 85) begin
      return $urandom_range(1, 3);
    end else if (r < 97) begin
      return $urandom_range(4, 12);
    end
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [FIELD_W-1:0] rand_elem();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) begin
      return '0;
    end else if (r == 1) begin
      return '1;
    end
    return FIELD_W'($urandom_range(0, ELEMENTS - 1));
  endfunction

  // called at a clock edge; returns at the edge where the item is taken
  task automatic send_item(logic f, logic [FIELD_W-1:0] a, logic [FIELD_W-1:0] b);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_valid <= 1'b1;
    func      <= f;
    elem_a    <= a;
    elem_b    <= b;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    sb.note_item(f, a, b);
  endtask

  task automatic send_noise();
    if ($urandom_range(0, 9) == 0) begin
      send_item(FUNC_JOIN, rand_elem(), rand_elem());
    end else if ($urandom_range(0, 1) == 0) begin
      send_item(FUNC_QUERY, rand_elem(), rand_elem());
    end
  endtask

  // pairwise merges of equal-sized subtrees over a span, random members each time
  task automatic build_span(int base, int span, int first_level);
    for (int s = first_level; s < span; s = s * 2) begin
      for (int i = 0; i < span; i += 2 * s) begin
        send_item(FUNC_JOIN, FIELD_W'(base + i + $urandom_range(0, s - 1)),
                  FIELD_W'(base + i + s + $urandom_range(0, s - 1)));
        send_noise();
      end
    end
  endtask

  initial begin
    int order[ELEMENTS / BLOCK];
    int j;
    int tmp;
    int target;
    sb        = new();
    calm      = 1'b0;
    rst       = 1'b1;
    req_valid = 1'b0;
    func      = FUNC_QUERY;
    elem_a    = '0;
    elem_b    = '0;
    rsp_stall = 1'b0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // same element twice, extremes, equal and unequal sizes, connected joins
    send_item(FUNC_QUERY, 10'd0, 10'd0);
    send_item(FUNC_JOIN, 10'd0, 10'd0);
    send_item(FUNC_JOIN, 10'd1023, 10'd1023);
    send_item(FUNC_QUERY, 10'd0, 10'd1023);
    send_item(FUNC_JOIN, 10'd0, 10'd1023);
    send_item(FUNC_JOIN, 10'd1023, 10'd0);
    send_item(FUNC_QUERY, 10'd1023, 10'd0);
    send_item(FUNC_JOIN, 10'd1, 10'd2);
    send_item(FUNC_JOIN, 10'd3, 10'd1);
    send_item(FUNC_JOIN, 10'd0, 10'd3);
    send_item(FUNC_QUERY, 10'd1023, 10'd3);
    send_item(FUNC_JOIN, 10'd512, 10'd511);
    send_item(FUNC_JOIN, 10'd513, 10'd514);
    send_item(FUNC_JOIN, 10'd514, 10'd511);
    send_item(FUNC_JOIN, 10'd1022, 10'd513);
    send_item(FUNC_QUERY, 10'd1022, 10'd512);
    send_item(FUNC_JOIN, 10'd682, 10'd341);
    send_item(FUNC_QUERY, 10'd341, 10'd682);
    send_item(FUNC_QUERY, 10'd1022, 10'd1);
    send_item(FUNC_JOIN, 10'd511, 10'd0);
    send_item(FUNC_QUERY, 10'd1023, 10'd1022);
    send_item(FUNC_JOIN, 10'd2, 10'd514);
    target = sb.noted + RANDOM_ITEMS;

    for (int k = 0; k < ELEMENTS / BLOCK; k++) begin
      order[k] = k;
    end
    for (int k = ELEMENTS / BLOCK - 1; k > 0; k--) begin
      j        = $urandom_range(0, k);
      tmp      = order[k];
      order[k] = order[j];
      order[j] = tmp;
    end

    // deep trees: build blocks bottom-up, then merge blocks the same way
    for (int k = 0; k < ELEMENTS / BLOCK; k++) begin
      calm = (k >= 20 && k < 28);
      build_span(order[k] * BLOCK, BLOCK, 1);
    end
    build_span(0, ELEMENTS, BLOCK);

    while (sb.noted < target) begin
      send_item(logic'($urandom_range(0, 1)), rand_elem(), rand_elem());
    end
    req_valid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

  // result side: check taken items, then pick the next stall value
  always @(posedge clk) begin
    if (!rst) begin
      if (rsp_valid && !rsp_stall) begin
        sb.check_result(connected, merged, root_a);
      end
      if (!held && sb.noted >= 500) begin
        held      = 1'b1;
        hold_left = 600;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_stall <= 1'b1;
      end else if (run_left > 0) begin
        run_left--;
      end else if (!calm && $urandom_range(0, 2) == 0) begin
        run_left  = pick_gap();
        rsp_stall <= 1'b1;
      end else begin
        run_left  = $urandom_range(0, 8);
        rsp_stall <= 1'b0;
      end
    end
  end

  initial begin
    hold_left = 0;
    run_left  = 0;
    held      = 1'b0;
    cycles    = 0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb: errors");
      $finish;
    end
  end

endmodule

### files.f
rtl/uf_pkg.sv
rtl/uf_ram.sv
rtl/uf_seq.sv
rtl/union_find_engine_core.sv
tb/tb.sv
